[rtl/core/detector_fault_history_log_top_defines.svh]
// assertion macros for the detector fault history log
// used by the top level, which must declare clock and reset
`ifndef DETECTOR_FAULT_HISTORY_LOG_TOP_DEFINES_SVH
`define DETECTOR_FAULT_HISTORY_LOG_TOP_DEFINES_SVH

// property checked on every edge outside reset
`define FHL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define FHL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/fhl_pkg.sv]
// shared types, sizes and codes for the detector fault history log
// no dependencies
package fhl_pkg;

   localparam int HIST_DEPTH    = 32;
   localparam int NUM_DETECTORS = 64;

   localparam int PTR_W = $clog2(HIST_DEPTH);
   localparam int PF_AW = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;

   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_OPEN   = 2'd1;
   localparam logic [1:0] ACT_CLOSE  = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [5:0]  detector;
      logic [2:0]  new_state;
      logic [31:0] timestamp;
      logic [4:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  slot;
      logic [2:0]  period_fault_type;
      logic [5:0]  entry_detector;
      logic [2:0]  entry_fault_type;
      logic [31:0] entry_start_time;
      logic [31:0] entry_end_time;
      logic        entry_open;
      logic        entry_valid;
      logic [4:0]  newest_pointer;
      logic [4:0]  oldest_pointer;
   } rsp_type;

   // one log record minus its end time, which lives in a ram of its own
   typedef struct packed {
      logic [5:0]  detector;
      logic [2:0]  fault_type;
      logic [31:0] start_time;
   } log_word_type;

endpackage

[rtl/core/fhl_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
module fhl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/detector_fault_history_log_top.sv]
// an event item runs a slot-by-slot search through the log ram, one compare per cycle,
// in ST_SCAN and ST_LAST, then waits in ST_DONE; a read item goes straight to ST_DONE
// one item at a time: no new item is accepted until the result of the last one is issued,
// and the result waits in ST_DONE while results stall
// reset clears pointers, written/closed bits and the period fault valid bits; no clear pass
// depends on fhl_pkg, fhl_ram and detector_fault_history_log_top_defines.svh
`include "detector_fault_history_log_top_defines.svh"

module detector_fault_history_log_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fhl_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output fhl_pkg::rsp_type rsp_data
);

   localparam int D  = fhl_pkg::HIST_DEPTH;
   localparam int PW = fhl_pkg::PTR_W;
   localparam int AW = fhl_pkg::PF_AW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   fhl_pkg::req_type      req_ff, req_in;
   logic [PW-1:0]         addr_ff, addr_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [PW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [PW-1:0]         found_idx_ff, found_idx_in;
   fhl_pkg::log_word_type found_word_ff, found_word_in;
   logic [PW-1:0]         write_slot_ff, write_slot_in;
   logic [PW-1:0]         oldest_slot_ff, oldest_slot_in;
   logic [D-1:0]          written_ff, written_in;
   logic [D-1:0]          closed_ff, closed_in;
   logic [fhl_pkg::NUM_DETECTORS-1:0] pf_vld_ff, pf_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fhl_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  fire;
   logic                  is_evt;
   logic                  do_open;
   logic                  do_close;
   logic                  det_ok;
   logic                  rd_ok;
   logic [PW-1:0]         rd_idx;
   logic [AW-1:0]         pf_idx;
   logic [2:0]            pf_cur;
   logic [2:0]            pf_new;
   logic [PW-1:0]         ws_step;
   logic [PW-1:0]         os_step;
   logic                  found_open;

   logic                  log_rd_en;
   logic [PW-1:0]         log_rd_addr;
   fhl_pkg::log_word_type log_rd_data;
   fhl_pkg::log_word_type log_wr_data;
   logic [31:0]           end_rd_data;
   logic [2:0]            pf_rd_data;
   logic                  pf_wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign is_evt   = (req_ff.cmd == fhl_pkg::CMD_EVENT);
   assign do_open  = is_evt && (req_ff.new_state != 3'd0) && !found_ff;
   assign do_close = is_evt && (req_ff.new_state == 3'd0) && found_ff;
   assign det_ok   = int'(req_ff.detector) < fhl_pkg::NUM_DETECTORS;
   assign rd_ok    = int'(req_ff.read_index) < D;
   assign rd_idx   = PW'(req_ff.read_index);
   assign pf_idx   = AW'(req_ff.detector);
   assign pf_cur   = pf_vld_ff[pf_idx] ? pf_rd_data : 3'd0;
   assign pf_new   = (pf_cur == 3'd0) ? req_ff.new_state : pf_cur;
   assign pf_wr_en = fire && is_evt && det_ok;

   assign found_open = written_ff[found_idx_ff] && !closed_ff[found_idx_ff];

   // pointers wrap modulo depth minus one, so the top slot stays unused
   assign ws_step = (write_slot_ff == PW'(D - 2)) ? '0 : write_slot_ff + 1'b1;
   assign os_step = (oldest_slot_ff == PW'(D - 2)) ? '0 : oldest_slot_ff + 1'b1;

   // search walks the slots in address order; reads issue the requested slot
   assign log_rd_en   = (state_ff == ST_SCAN) ||
                        (accept && req_data.cmd == fhl_pkg::CMD_READ);
   assign log_rd_addr = (state_ff == ST_SCAN) ? addr_ff : PW'(req_data.read_index);

   assign log_wr_data.detector   = req_ff.detector;
   assign log_wr_data.fault_type = req_ff.new_state;
   assign log_wr_data.start_time = req_ff.timestamp;

   fhl_ram #(
      .WIDTH($bits(fhl_pkg::log_word_type)),
      .DEPTH(D)
   ) u_log_ram (
      .clock  (clock),
      .wr_en  (fire && do_open),
      .wr_addr(write_slot_ff),
      .wr_data(log_wr_data),
      .rd_en  (log_rd_en),
      .rd_addr(log_rd_addr),
      .rd_data(log_rd_data)
   );

   fhl_ram #(
      .WIDTH(32),
      .DEPTH(D)
   ) u_end_ram (
      .clock  (clock),
      .wr_en  (fire && do_close),
      .wr_addr(found_idx_ff),
      .wr_data(req_ff.timestamp),
      .rd_en  (log_rd_en),
      .rd_addr(log_rd_addr),
      .rd_data(end_rd_data)
   );

   fhl_ram #(
      .WIDTH(3),
      .DEPTH(fhl_pkg::NUM_DETECTORS)
   ) u_pf_ram (
      .clock  (clock),
      .wr_en  (pf_wr_en),
      .wr_addr(pf_idx),
      .wr_data(pf_new),
      .rd_en  (accept),
      .rd_addr(AW'(req_data.detector)),
      .rd_data(pf_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      addr_in        = addr_ff;
      cmp_vld_in     = (state_ff == ST_SCAN);
      cmp_idx_in     = addr_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_word_in  = found_word_ff;
      write_slot_in  = write_slot_ff;
      oldest_slot_in = oldest_slot_ff;
      written_in     = written_ff;
      closed_in      = closed_ff;
      pf_vld_in      = pf_vld_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      // compare stage, one slot behind the ram address; first match wins
      if (cmp_vld_ff && !found_ff && written_ff[cmp_idx_ff] && !closed_ff[cmp_idx_ff]
          && log_rd_data.detector == req_ff.detector) begin
         found_in      = 1'b1;
         found_idx_in  = cmp_idx_ff;
         found_word_in = log_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               addr_in  = '0;
               found_in = 1'b0;
               state_in = (req_data.cmd == fhl_pkg::CMD_READ) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == PW'(D - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (!is_evt) begin
                  rsp_data_in.action = fhl_pkg::ACT_READ;
                  rsp_data_in.slot   = req_ff.read_index;
                  if (rd_ok && written_ff[rd_idx]) begin
                     rsp_data_in.entry_detector   = log_rd_data.detector;
                     rsp_data_in.entry_fault_type = log_rd_data.fault_type;
                     rsp_data_in.entry_start_time = log_rd_data.start_time;
                     rsp_data_in.entry_end_time   = closed_ff[rd_idx] ? end_rd_data : 32'd0;
                     rsp_data_in.entry_open       = !closed_ff[rd_idx];
                     rsp_data_in.entry_valid      = 1'b1;
                  end
               end else begin
                  if (det_ok) begin
                     pf_vld_in[pf_idx]                = 1'b1;
                     rsp_data_in.period_fault_type    = pf_new;
                  end
                  if (do_open) begin
                     written_in[write_slot_ff] = 1'b1;
                     closed_in[write_slot_ff]  = 1'b0;
                     write_slot_in             = ws_step;
                     if (ws_step <= oldest_slot_ff) begin
                        oldest_slot_in = os_step;
                     end
                     rsp_data_in.action           = fhl_pkg::ACT_OPEN;
                     rsp_data_in.slot             = 5'(write_slot_ff);
                     rsp_data_in.entry_detector   = req_ff.detector;
                     rsp_data_in.entry_fault_type = req_ff.new_state;
                     rsp_data_in.entry_start_time = req_ff.timestamp;
                     rsp_data_in.entry_open       = 1'b1;
                     rsp_data_in.entry_valid      = 1'b1;
                  end else if (do_close) begin
                     closed_in[found_idx_ff]      = 1'b1;
                     rsp_data_in.action           = fhl_pkg::ACT_CLOSE;
                     rsp_data_in.slot             = 5'(found_idx_ff);
                     rsp_data_in.entry_detector   = found_word_ff.detector;
                     rsp_data_in.entry_fault_type = found_word_ff.fault_type;
                     rsp_data_in.entry_start_time = found_word_ff.start_time;
                     rsp_data_in.entry_end_time   = req_ff.timestamp;
                     rsp_data_in.entry_valid      = 1'b1;
                  end else begin
                     rsp_data_in.action = fhl_pkg::ACT_NONE;
                  end
               end
               rsp_data_in.newest_pointer = 5'(write_slot_in);
               rsp_data_in.oldest_pointer = 5'(oldest_slot_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cmp_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         write_slot_ff  <= '0;
         oldest_slot_ff <= '0;
         written_ff     <= '0;
         closed_ff      <= '0;
         pf_vld_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmp_vld_ff     <= cmp_vld_in;
         found_ff       <= found_in;
         write_slot_ff  <= write_slot_in;
         oldest_slot_ff <= oldest_slot_in;
         written_ff     <= written_in;
         closed_ff      <= closed_in;
         pf_vld_ff      <= pf_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_idx_ff  <= found_idx_in;
      found_word_ff <= found_word_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FHL_ASSERT(a_write_slot_range, write_slot_ff != PW'(D - 1), "write slot on unused slot")
   `FHL_ASSERT(a_oldest_slot_range, oldest_slot_ff != PW'(D - 1), "oldest slot on unused slot")
   `FHL_ASSERT(a_found_is_open, (state_ff == ST_DONE && found_ff) |-> found_open, "match not open")
   `FHL_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "early result")
   `FHL_ASSERT(a_accept_busy, accept |=> (state_ff != ST_IDLE), "accepted item did not start work")

endmodule

[tb/detector_fault_history_log_top_tb.sv]
// testbench for detector_fault_history_log_top: directed and random events and reads,
// checked item by item against a scoreboard that tracks the fault log in parallel
// depends on fhl_pkg and the rtl of detector_fault_history_log_top
module detector_fault_history_log_top_tb;

   localparam int RUN_LIMIT        = 400000;
   localparam int HOLD_CYCLES      = 300;
   localparam int HOLD_AT          = 60;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int DRAIN_CYCLES     = 2 * fhl_pkg::HIST_DEPTH + 4;

   class fault_log_scoreboard;
      bit [5:0]    rec_detector [fhl_pkg::HIST_DEPTH];
      bit [2:0]    rec_fault    [fhl_pkg::HIST_DEPTH];
      bit [31:0]   rec_start    [fhl_pkg::HIST_DEPTH];
      bit [31:0]   rec_end      [fhl_pkg::HIST_DEPTH];
      bit          rec_closed   [fhl_pkg::HIST_DEPTH];
      bit          rec_written  [fhl_pkg::HIST_DEPTH];
      bit [2:0]    sticky_fault [fhl_pkg::NUM_DETECTORS];
      int unsigned write_ptr  = 0;
      int unsigned oldest_ptr = 0;
      fhl_pkg::rsp_type pending_log_results [$];
      int          errors = 0;

      function fhl_pkg::rsp_type with_entry(fhl_pkg::rsp_type r, int s);
         if (rec_written[s]) begin
            r.entry_detector   = rec_detector[s];
            r.entry_fault_type = rec_fault[s];
            r.entry_start_time = rec_start[s];
            r.entry_end_time   = rec_closed[s] ? rec_end[s] : 32'd0;
            r.entry_open       = !rec_closed[s];
            r.entry_valid      = 1'b1;
         end
         return r;
      endfunction

      function fhl_pkg::rsp_type predict_log_result(fhl_pkg::req_type q);
         fhl_pkg::rsp_type r;
         int found;
         int w;
         r = '0;
         found = -1;
         if (q.cmd == fhl_pkg::CMD_READ) begin
            r.action = fhl_pkg::ACT_READ;
            r.slot   = q.read_index;
            r = with_entry(r, int'(q.read_index));
         end else begin
            for (int i = 0; i < fhl_pkg::HIST_DEPTH && found < 0; i++)
               if (rec_written[i] && !rec_closed[i] && rec_detector[i] == q.detector)
                  found = i;
            // period fault type latches the first nonzero state seen after reset
            if (sticky_fault[q.detector] == 3'd0)
               sticky_fault[q.detector] = q.new_state;
            r.period_fault_type = sticky_fault[q.detector];
            if (q.new_state != 3'd0 && found < 0) begin
               w = int'(write_ptr);
               rec_detector[w] = q.detector;
               rec_fault[w]    = q.new_state;
               rec_start[w]    = q.timestamp;
               rec_closed[w]   = 1'b0;
               rec_written[w]  = 1'b1;
               // ring wraps one short of the depth, top slot stays unused
               write_ptr = (write_ptr + 1) % (fhl_pkg::HIST_DEPTH - 1);
               if (write_ptr <= oldest_ptr)
                  oldest_ptr = (oldest_ptr + 1) % (fhl_pkg::HIST_DEPTH - 1);
               r.action = fhl_pkg::ACT_OPEN;
               r.slot   = 5'(w);
               r = with_entry(r, w);
            end else if (q.new_state == 3'd0 && found >= 0) begin
               rec_end[found]    = q.timestamp;
               rec_closed[found] = 1'b1;
               r.action = fhl_pkg::ACT_CLOSE;
               r.slot   = 5'(found);
               r = with_entry(r, found);
            end
         end
         r.newest_pointer = 5'(write_ptr);
         r.oldest_pointer = 5'(oldest_ptr);
         return r;
      endfunction

      function void note_request(fhl_pkg::req_type q);
         pending_log_results.push_back(predict_log_result(q));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(fhl_pkg::rsp_type got);
         fhl_pkg::rsp_type want;
         if (pending_log_results.size() == 0) begin
            $error("unexpected result item: %h", got);
            errors++;
            return;
         end
         want = pending_log_results.pop_front();
         compare_field("action", 32'(want.action), 32'(got.action));
         compare_field("slot", 32'(want.slot), 32'(got.slot));
         compare_field("period_fault_type",
                       32'(want.period_fault_type), 32'(got.period_fault_type));
         compare_field("entry_detector", 32'(want.entry_detector), 32'(got.entry_detector));
         compare_field("entry_fault_type",
                       32'(want.entry_fault_type), 32'(got.entry_fault_type));
         compare_field("entry_start_time", want.entry_start_time, got.entry_start_time);
         compare_field("entry_end_time", want.entry_end_time, got.entry_end_time);
         compare_field("entry_open", 32'(want.entry_open), 32'(got.entry_open));
         compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
         compare_field("newest_pointer", 32'(want.newest_pointer), 32'(got.newest_pointer));
         compare_field("oldest_pointer", 32'(want.oldest_pointer), 32'(got.oldest_pointer));
      endfunction

      // only slots that hold a record are ever read back
      function int pick_written_slot();
         int slots [$];
         for (int i = 0; i < fhl_pkg::HIST_DEPTH; i++)
            if (rec_written[i])
               slots.push_back(i);
         if (slots.size() == 0)
            return -1;
         return slots[$urandom_range(slots.size() - 1)];
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fhl_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fhl_pkg::rsp_type rsp_data;

   fault_log_scoreboard history = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int accepted_items = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int cycle_count    = 0;

   detector_fault_history_log_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off to back up the input
   always @(negedge clock) begin
      if (!hold_done && accepted_items >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         history.check_response(rsp_data);
   end

   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_item(input fhl_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      history.note_request(item);
      accepted_items++;
      @(negedge clock);
   endtask

   function automatic fhl_pkg::req_type make_event(bit [5:0] det, bit [2:0] st, bit [31:0] ts);
      fhl_pkg::req_type q;
      q.cmd        = fhl_pkg::CMD_EVENT;
      q.detector   = det;
      q.new_state  = st;
      q.timestamp  = ts;
      q.read_index = 5'($urandom);
      return q;
   endfunction

   function automatic fhl_pkg::req_type make_read(bit [4:0] idx);
      fhl_pkg::req_type q;
      q.cmd        = fhl_pkg::CMD_READ;
      q.detector   = 6'($urandom);
      q.new_state  = 3'($urandom);
      q.timestamp  = $urandom;
      q.read_index = idx;
      return q;
   endfunction

   function automatic fhl_pkg::req_type random_item();
      fhl_pkg::req_type q;
      int s;
      q = make_event(6'($urandom), 3'($urandom), $urandom);
      if ($urandom_range(99) < 20) begin
         s = history.pick_written_slot();
         if (s >= 0) begin
            q.cmd        = fhl_pkg::CMD_READ;
            q.read_index = 5'(s);
         end
      end
      if (q.cmd == fhl_pkg::CMD_EVENT) begin
         // a small pool of detectors so that records get opened and closed
         if ($urandom_range(99) < 80)
            q.detector = 6'($urandom_range(9));
         if ($urandom_range(99) < 45)
            q.new_state = 3'd0;
         else if (q.new_state == 3'd0)
            q.new_state = 3'($urandom_range(7, 1));
      end
      return q;
   endfunction

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++)
         send_item(random_item());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(make_event(6'd0, 3'd7, 32'h0000_0000));
      send_item(make_event(6'd0, 3'd3, 32'h0000_0001));
      send_item(make_event(6'd63, 3'd1, 32'hFFFF_FFFF));
      send_item(make_event(6'd5, 3'd0, 32'h0000_0005));
      send_item(make_event(6'd0, 3'd0, 32'h0000_0064));
      send_item(make_read(5'd0));
      send_item(make_read(5'd1));
      send_item(make_event(6'd0, 3'd2, 32'h0000_00C8));
      send_item(make_event(6'd63, 3'd0, 32'hFFFF_FFFF));
      send_item(make_read(5'd1));
      send_item(make_read(5'd2));
      send_item(make_event(6'd42, 3'd4, 32'h8000_0000));
      send_item(make_event(6'd21, 3'd5, 32'h7FFF_FFFF));
      send_item(make_event(6'd42, 3'd6, 32'h0000_0007));
      send_item(make_event(6'd42, 3'd0, 32'h0000_0008));
      send_item(make_event(6'd21, 3'd0, 32'h0000_0009));
      send_item(make_event(6'd0, 3'd0, 32'h0000_012C));
      send_item(make_event(6'd0, 3'd0, 32'h0000_012D));
      send_item(make_read(5'd3));
      send_item(make_read(5'd4));

      run_random(RANDOM_PER_PHASE, 0, 0);
      run_random(RANDOM_PER_PHASE, 73, 0);
      run_random(RANDOM_PER_PHASE, 0, 73);
      run_random(RANDOM_PER_PHASE, 34, 34);
      req_valid <= 1'b0;

      while (history.pending_log_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (history.errors == 0 && history.pending_log_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
